// ----- design/psd_pkg.sv -----
package psd_pkg;

  localparam int CoordW = 16;                 // signed Q8.8 coordinate
  localparam int DiffW  = CoordW + 1;         // coordinate difference
  localparam int MagW   = CoordW;             // |difference|
  localparam int LenW   = 2 * CoordW + 2;     // squared length d.d
  localparam int ProjW  = 2 * CoordW + 3;     // signed projection w.d
  localparam int DenW   = LenW + 1;           // 2 * d.d
  localparam int QW     = CoordW + 1;         // quotient bits, one per divider cell
  localparam int NumW   = DenW + QW;          // 2*T*|d| + L
  localparam int VW     = CoordW + 3;         // signed offset to closest point
  localparam int VMagW  = CoordW + 2;
  localparam int SqW    = 2 * VMagW;
  localparam int SumW   = SqW + 2;            // sum of three squares
  localparam int RtW    = SumW / 2;           // root bits, one per sqrt cell
  localparam int RemW   = RtW + 2;
  localparam int DistW  = 17;
  localparam int RegionW = 2;

  typedef enum logic [RegionW-1:0] {
    RegDegen    = 2'd0,
    RegBefore   = 2'd1,
    RegPast     = 2'd2,
    RegInterior = 2'd3
  } region_e;

  // data that rides alongside the divider chain
  typedef struct packed {
    logic [2:0][DiffW-1:0] w;     // P - S
    logic [2:0][DiffW-1:0] pe;    // P - E
    logic [2:0]            dneg;  // sign of E - S
    region_e               region;
  } side_t;

endpackage

// ----- design/psd_div_cell.sv -----
module psd_div_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [psd_pkg::DenW-1:0]  den_i,
  input  logic [psd_pkg::DenW-1:0]  rem_i,
  input  logic [psd_pkg::QW-1:0]    rest_i,
  input  logic [psd_pkg::QW-1:0]    quo_i,
  output logic [psd_pkg::DenW-1:0]  den_o,
  output logic [psd_pkg::DenW-1:0]  rem_o,
  output logic [psd_pkg::QW-1:0]    rest_o,
  output logic [psd_pkg::QW-1:0]    quo_o
);

  logic [psd_pkg::DenW:0]   trial;
  logic [psd_pkg::DenW:0]   diff;
  logic                     ge;
  logic [psd_pkg::DenW-1:0] rem_d;

  // one restoring step: bring down the next numerator bit
  assign trial = {rem_i, rest_i[psd_pkg::QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = trial >= {1'b0, den_i};
  assign rem_d = ge ? diff[psd_pkg::DenW-1:0] : trial[psd_pkg::DenW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o  <= den_i;
      rem_o  <= rem_d;
      rest_o <= {rest_i[psd_pkg::QW-2:0], 1'b0};
      quo_o  <= {quo_i[psd_pkg::QW-2:0], ge};
    end
  end

endmodule

// ----- design/psd_sqrt_cell.sv -----
module psd_sqrt_cell (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [psd_pkg::SumW-1:0]  rad_i,
  input  logic [psd_pkg::RemW-1:0]  rem_i,
  input  logic [psd_pkg::RtW-1:0]   root_i,
  output logic [psd_pkg::SumW-1:0]  rad_o,
  output logic [psd_pkg::RemW-1:0]  rem_o,
  output logic [psd_pkg::RtW-1:0]   root_o
);

  logic [psd_pkg::RemW+1:0] r;
  logic [psd_pkg::RemW+1:0] trial;
  logic [psd_pkg::RemW+1:0] diff;
  logic                     ge;

  // one root digit: two radicand bits in, trial 4*root+1
  assign r     = {rem_i, rad_i[psd_pkg::SumW-1 -: 2]};
  assign trial = {{(psd_pkg::RemW - psd_pkg::RtW){1'b0}}, root_i, 2'b01};
  assign diff  = r - trial;
  assign ge    = r >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o  <= {rad_i[psd_pkg::SumW-3:0], 2'b00};
      rem_o  <= ge ? diff[psd_pkg::RemW-1:0] : r[psd_pkg::RemW-1:0];
      root_o <= {root_i[psd_pkg::RtW-2:0], ge};
    end
  end

endmodule

// ----- design/point_segment_distance_3d_unit.sv -----
// Point to segment distance in 3D, fixed point.
//
// Input channel (s_axis): one item carries the query point P, the segment
// start S and the segment end E, nine signed Q8.8 coordinates packed in
// tdata. Output channel (m_axis): one result item per input item, tdata
// holds the distance (unsigned Q9.8, floor square root, saturated at
// 17'h1FFFF) and tuser holds the region code (degenerate segment, before
// start, past end, interior).
//
// Throughput: one item per cycle while the receiver takes the output. The
// pipeline holds setup stages for difference, product, sum and numerator,
// 17 divider cells (one quotient bit each), offset, square and sum stages,
// 19 square root cells (one root bit each) and the output register.
// The whole chain advances as one; it moves whenever the output register
// is empty or is being taken, so a stalled receiver holds every stage and
// tready drops only while the output item waits.
//
// Reset clears the valid bits of every stage; the block keeps no other
// state between items.
module point_segment_distance_3d_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [143:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // distance [16:0], zero fill [23:17]
  output logic [23:0]  m_axis_tdata_o,
  // region [1:0]
  output logic [1:0]   m_axis_tuser_o
);

  localparam int CW = psd_pkg::CoordW;

  logic en;
  logic s_fire;

  // stage A: differences
  logic                              a_vld_q;
  logic signed [psd_pkg::DiffW-1:0]  a_d_q  [3];
  logic signed [psd_pkg::DiffW-1:0]  a_w_q  [3];
  logic signed [psd_pkg::DiffW-1:0]  a_pe_q [3];

  // stage B: products
  logic                                b_vld_q;
  logic signed [2*psd_pkg::DiffW-1:0]  b_dd_q [3];
  logic signed [2*psd_pkg::DiffW-1:0]  b_wd_q [3];
  logic signed [psd_pkg::DiffW-1:0]    b_d_q  [3];
  logic signed [psd_pkg::DiffW-1:0]    b_w_q  [3];
  logic signed [psd_pkg::DiffW-1:0]    b_pe_q [3];

  // stage C: squared length, projection, region
  logic                              c_vld_q;
  logic [psd_pkg::LenW-1:0]          c_len_q;
  logic signed [psd_pkg::ProjW-1:0]  c_proj_q;
  psd_pkg::region_e                  c_region_q;
  logic signed [psd_pkg::DiffW-1:0]  c_d_q  [3];
  logic signed [psd_pkg::DiffW-1:0]  c_w_q  [3];
  logic signed [psd_pkg::DiffW-1:0]  c_pe_q [3];
  logic [psd_pkg::LenW-1:0]          len_sum;
  logic signed [psd_pkg::ProjW-1:0]  proj_sum;
  psd_pkg::region_e                  region_c;

  // stage D and divider chain
  logic [psd_pkg::NumW-1:0]  d_num_q [3];
  logic [psd_pkg::DenW-1:0]  d_den_q;
  psd_pkg::side_t            dv_side_q [psd_pkg::QW+1];
  logic                      dv_vld_q  [psd_pkg::QW+1];
  logic [psd_pkg::DenW-1:0]  dv_den  [3][psd_pkg::QW+1];
  logic [psd_pkg::DenW-1:0]  dv_rem  [3][psd_pkg::QW+1];
  logic [psd_pkg::QW-1:0]    dv_rest [3][psd_pkg::QW+1];
  logic [psd_pkg::QW-1:0]    dv_quo  [3][psd_pkg::QW+1];

  // stages E, F, G
  logic                          e_vld_q;
  logic [psd_pkg::VMagW-1:0]     e_mag_q [3];
  psd_pkg::region_e              e_region_q;
  logic                          f_vld_q;
  logic [psd_pkg::SqW-1:0]       f_sq_q [3];
  psd_pkg::region_e              f_region_q;

  // square root chain, index 0 is stage G
  logic [psd_pkg::SumW-1:0]  g_sum_q;
  logic                      sq_vld_q    [psd_pkg::RtW+1];
  psd_pkg::region_e          sq_region_q [psd_pkg::RtW+1];
  logic [psd_pkg::SumW-1:0]  sq_rad  [psd_pkg::RtW+1];
  logic [psd_pkg::RemW-1:0]  sq_rem  [psd_pkg::RtW+1];
  logic [psd_pkg::RtW-1:0]   sq_root [psd_pkg::RtW+1];

  // output register
  logic                         m_vld_q;
  logic [psd_pkg::DistW-1:0]    m_dist_q;
  psd_pkg::region_e             m_region_q;

  assign en              = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign s_fire          = s_axis_tvalid_i && en;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      for (int k = 0; k <= psd_pkg::QW; k++) dv_vld_q[k] <= 1'b0;
      for (int k = 0; k <= psd_pkg::RtW; k++) sq_vld_q[k] <= 1'b0;
    end else if (en) begin
      a_vld_q     <= s_axis_tvalid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      dv_vld_q[0] <= c_vld_q;
      for (int k = 0; k < psd_pkg::QW; k++) dv_vld_q[k+1] <= dv_vld_q[k];
      e_vld_q     <= dv_vld_q[psd_pkg::QW];
      f_vld_q     <= e_vld_q;
      sq_vld_q[0] <= f_vld_q;
      for (int k = 0; k < psd_pkg::RtW; k++) sq_vld_q[k+1] <= sq_vld_q[k];
      m_vld_q     <= sq_vld_q[psd_pkg::RtW];
    end
  end

  // stages A and B
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_d_q[i]  <= psd_pkg::DiffW'($signed(s_axis_tdata_i[(6+i)*CW +: CW]))
                   - psd_pkg::DiffW'($signed(s_axis_tdata_i[(3+i)*CW +: CW]));
        a_w_q[i]  <= psd_pkg::DiffW'($signed(s_axis_tdata_i[i*CW +: CW]))
                   - psd_pkg::DiffW'($signed(s_axis_tdata_i[(3+i)*CW +: CW]));
        a_pe_q[i] <= psd_pkg::DiffW'($signed(s_axis_tdata_i[i*CW +: CW]))
                   - psd_pkg::DiffW'($signed(s_axis_tdata_i[(6+i)*CW +: CW]));
        b_dd_q[i] <= a_d_q[i] * a_d_q[i];
        b_wd_q[i] <= a_w_q[i] * a_d_q[i];
        b_d_q[i]  <= a_d_q[i];
        b_w_q[i]  <= a_w_q[i];
        b_pe_q[i] <= a_pe_q[i];
      end
    end
  end

  // stage C
  always_comb begin
    len_sum  = '0;
    proj_sum = '0;
    for (int i = 0; i < 3; i++) begin
      len_sum  = len_sum + psd_pkg::LenW'(b_dd_q[i][2*psd_pkg::DiffW-2:0]);
      proj_sum = proj_sum + psd_pkg::ProjW'(b_wd_q[i]);
    end
    if (len_sum == '0) begin
      region_c = psd_pkg::RegDegen;
    end else if (proj_sum[psd_pkg::ProjW-1]) begin
      region_c = psd_pkg::RegBefore;
    end else if (proj_sum[psd_pkg::LenW-1:0] > len_sum) begin
      region_c = psd_pkg::RegPast;
    end else begin
      region_c = psd_pkg::RegInterior;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_len_q    <= len_sum;
      c_proj_q   <= proj_sum;
      c_region_q <= region_c;
      for (int i = 0; i < 3; i++) begin
        c_d_q[i]  <= b_d_q[i];
        c_w_q[i]  <= b_w_q[i];
        c_pe_q[i] <= b_pe_q[i];
      end
    end
  end

  // stage D: numerator 2*T*|d| + L, denominator 2*L, and side data
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_den_q <= {c_len_q, 1'b0};
      for (int i = 0; i < 3; i++) begin
        logic [psd_pkg::DiffW-1:0] dmag;
        dmag = c_d_q[i][psd_pkg::DiffW-1] ? psd_pkg::DiffW'(-c_d_q[i])
                                          : psd_pkg::DiffW'(c_d_q[i]);
        d_num_q[i] <= (psd_pkg::NumW'(c_proj_q[psd_pkg::LenW-1:0]
                                      * dmag[psd_pkg::MagW-1:0]) << 1)
                    + psd_pkg::NumW'(c_len_q);
        dv_side_q[0].w[i]    <= c_w_q[i];
        dv_side_q[0].pe[i]   <= c_pe_q[i];
        dv_side_q[0].dneg[i] <= c_d_q[i][psd_pkg::DiffW-1];
      end
      dv_side_q[0].region <= c_region_q;
      for (int k = 0; k < psd_pkg::QW; k++) dv_side_q[k+1] <= dv_side_q[k];
    end
  end

  // divider chain, three lanes
  for (genvar ln = 0; ln < 3; ln++) begin : g_lane
    assign dv_den[ln][0]  = d_den_q;
    assign dv_rem[ln][0]  = d_num_q[ln][psd_pkg::NumW-1 -: psd_pkg::DenW];
    assign dv_rest[ln][0] = d_num_q[ln][psd_pkg::QW-1:0];
    assign dv_quo[ln][0]  = '0;
    for (genvar k = 0; k < psd_pkg::QW; k++) begin : g_cell
      psd_div_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .den_i  (dv_den[ln][k]),
        .rem_i  (dv_rem[ln][k]),
        .rest_i (dv_rest[ln][k]),
        .quo_i  (dv_quo[ln][k]),
        .den_o  (dv_den[ln][k+1]),
        .rem_o  (dv_rem[ln][k+1]),
        .rest_o (dv_rest[ln][k+1]),
        .quo_o  (dv_quo[ln][k+1])
      );
    end
  end

  // stages E, F, G: offset to closest point, squares, sum
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [psd_pkg::VW-1:0] v;
        logic signed [psd_pkg::VW-1:0] q;
        q = psd_pkg::VW'(dv_quo[i][psd_pkg::QW]);
        case (dv_side_q[psd_pkg::QW].region)
          psd_pkg::RegPast: begin
            v = psd_pkg::VW'($signed(dv_side_q[psd_pkg::QW].pe[i]));
          end
          psd_pkg::RegInterior: begin
            v = dv_side_q[psd_pkg::QW].dneg[i]
              ? psd_pkg::VW'($signed(dv_side_q[psd_pkg::QW].w[i])) + q
              : psd_pkg::VW'($signed(dv_side_q[psd_pkg::QW].w[i])) - q;
          end
          default: begin
            v = psd_pkg::VW'($signed(dv_side_q[psd_pkg::QW].w[i]));
          end
        endcase
        e_mag_q[i] <= v[psd_pkg::VW-1] ? psd_pkg::VMagW'(-v) : psd_pkg::VMagW'(v);
        f_sq_q[i]  <= e_mag_q[i] * e_mag_q[i];
      end
      e_region_q     <= dv_side_q[psd_pkg::QW].region;
      f_region_q     <= e_region_q;
      g_sum_q        <= psd_pkg::SumW'(f_sq_q[0]) + psd_pkg::SumW'(f_sq_q[1])
                      + psd_pkg::SumW'(f_sq_q[2]);
      sq_region_q[0] <= f_region_q;
      for (int k = 0; k < psd_pkg::RtW; k++) sq_region_q[k+1] <= sq_region_q[k];
    end
  end

  // square root chain
  assign sq_rad[0]  = g_sum_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  for (genvar k = 0; k < psd_pkg::RtW; k++) begin : g_sqrt
    psd_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // output register, saturate to 17 bits
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_dist_q   <= (|sq_root[psd_pkg::RtW][psd_pkg::RtW-1:psd_pkg::DistW]) ? '1
                  : sq_root[psd_pkg::RtW][psd_pkg::DistW-1:0];
      m_region_q <= sq_region_q[psd_pkg::RtW];
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {7'b0, m_dist_q};
  assign m_axis_tuser_o  = m_region_q;

  // an accepted item shows up in the first stage
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> a_vld_q)
    else $error("accepted item lost at first stage");

  // a held chain keeps its divider valid bits
  a_hold_divider : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_vld_q[psd_pkg::QW]) && $stable(dv_vld_q[0]))
    else $error("divider chain moved while stalled");

  // an item leaving the last root cell reaches the output register
  a_out_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && sq_vld_q[psd_pkg::RtW]) |=> m_vld_q)
    else $error("result dropped before output register");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [16:0]      distance;
    psd_pkg::region_e region;
  } seg_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [23:0]  m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;

  logic [143:0] query_q[$];
  seg_result_t  dist_q[$];
  int           errors;
  int           n_sent;
  int           n_recv;
  int           region_seen[4];
  bit           hold_sender;
  bit           stim_done;
  int           send_gap;
  int           recv_gap;
  // handshake seen at the rising edge; consumed by the driver at falling edge
  bit           accepted_flag;

  point_segment_distance_3d_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [16:0] vec_len(longint v0, longint v1, longint v2);
    longint vs[3];
    longint unsigned m;
    longint unsigned sum;
    longint unsigned r;
    vs[0] = v0; vs[1] = v1; vs[2] = v2;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m = (vs[i] < 0) ? -vs[i] : vs[i];
      if (m > 17'h1FFFF) return 17'h1FFFF;
      sum += m * m;
    end
    r = isqrt(sum);
    return (r > 17'h1FFFF) ? 17'h1FFFF : r[16:0];
  endfunction

  // closest point on segment, distance and region
  function automatic seg_result_t seg_distance(logic [143:0] q);
    longint p[3], s[3], e[3], d[3], w[3], v[3];
    longint len2, proj, mag, qv;
    seg_result_t r;
    for (int i = 0; i < 3; i++) begin
      p[i] = $signed(q[16*i +: 16]);
      s[i] = $signed(q[16*(3+i) +: 16]);
      e[i] = $signed(q[16*(6+i) +: 16]);
      d[i] = e[i] - s[i];
      w[i] = p[i] - s[i];
    end
    // magnitudes fit: len2 < 2^34, proj < 2^35
    len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    proj = w[0]*d[0] + w[1]*d[1] + w[2]*d[2];
    if (len2 == 0) begin
      r.region = psd_pkg::RegDegen;
      r.distance = vec_len(w[0], w[1], w[2]);
    end else if (proj < 0) begin
      r.region = psd_pkg::RegBefore;
      r.distance = vec_len(w[0], w[1], w[2]);
    end else if (proj > len2) begin
      r.region = psd_pkg::RegPast;
      r.distance = vec_len(p[0]-e[0], p[1]-e[1], p[2]-e[2]);
    end else begin
      r.region = psd_pkg::RegInterior;
      for (int i = 0; i < 3; i++) begin
        mag = (d[i] < 0) ? -d[i] : d[i];
        // proj <= len2 so proj*mag < 2^52, no overflow
        qv = (2*proj*mag + len2) / (2*len2);
        v[i] = w[i] - ((d[i] < 0) ? -qv : qv);
      end
      r.distance = vec_len(v[0], v[1], v[2]);
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom());
      1: return 16'($signed($urandom_range(0, 2048)) - 1024);
      default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
    endcase
  endfunction

  function automatic logic [143:0] pack_pse(logic [15:0] c[9]);
    logic [143:0] t;
    for (int i = 0; i < 9; i++) t[16*i +: 16] = c[i];
    return t;
  endfunction

  // driver: presents the head of query_q, new item at falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || accepted_flag) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (query_q.size() > 0 && !hold_sender) begin
          s_axis_tdata_i <= query_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= (recv_gap == 0);
      recv_gap <= (recv_gap > 0) ? recv_gap - 1 : (m_axis_tready_i ? pick_gap() : 0);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accepted_flag <= 1'b0;
    end else begin
      accepted_flag <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        dist_q.push_back(seg_distance(s_axis_tdata_i));
        n_sent <= n_sent + 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    seg_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_recv <= n_recv + 1;
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected result dist=%h region=%0d", $time,
                 m_axis_tdata_o[16:0], m_axis_tuser_o);
        errors++;
      end else begin
        exp_r = dist_q.pop_front();
        region_seen[exp_r.region]++;
        if (m_axis_tdata_o[16:0] !== exp_r.distance) begin
          $display("%0t: distance expected %h actual %h", $time, exp_r.distance,
                   m_axis_tdata_o[16:0]);
          errors++;
        end
        if (m_axis_tuser_o !== exp_r.region) begin
          $display("%0t: region expected %0d actual %0d", $time, exp_r.region,
                   m_axis_tuser_o);
          errors++;
        end
        if (m_axis_tdata_o[23:17] !== 7'd0) begin
          $display("%0t: fill expected 0 actual %h", $time, m_axis_tdata_o[23:17]);
          errors++;
        end
      end
    end
  end

  task automatic add_query(logic [15:0] c[9]);
    query_q.push_back(pack_pse(c));
  endtask

  initial begin
    logic [15:0] c[9];
    int mode;
    int kind;
    longint t;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    hold_sender = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    foreach (region_seen[i]) region_seen[i] = 0;

    // directed: degenerate, before, past, interior, ties, extremes
    c = '{16'h0100, 16'h0200, 16'h0300, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    add_query(c);                                       // zero-length segment
    c = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
          16'h7FFF, 16'h7FFF, 16'h7FFF};
    add_query(c);                                       // degenerate, max distance
    c = '{16'hFF00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0};
    add_query(c);                                       // before start
    c = '{16'h0500, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0};
    add_query(c);                                       // past end
    c = '{16'h0200, 16'h0300, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0};
    add_query(c);                                       // interior
    c = '{16'h0, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0};
    add_query(c);                                       // projection exactly zero
    c = '{16'h0400, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0400, 16'h0, 16'h0};
    add_query(c);                                       // projection equals length
    c = '{16'h0001, 16'h0005, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0002, 16'h0001, 16'h0};
    add_query(c);                                       // quotient rounding
    c = '{16'h0003, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFE, 16'hFFFF, 16'h0};
    add_query(c);                                       // negative direction
    c = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
          16'h7FFF, 16'h8000, 16'h7FFF};
    add_query(c);                                       // extremes
    c = '{16'h8000, 16'h7FFF, 16'h0, 16'h7FFF, 16'h8000, 16'h8000,
          16'h8000, 16'h7FFF, 16'h7FFF};
    add_query(c);
    c = '{16'h0, 16'h8000, 16'h0, 16'h8000, 16'h0, 16'h7FFF, 16'h7FFF, 16'h0, 16'h8000};
    add_query(c);
    for (int i = 0; i < 9; i++) c[i] = 16'hFFFF;
    add_query(c);
    for (int i = 0; i < 9; i++) c[i] = 16'h0;
    add_query(c);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int n = 0; n < 1550; n++) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        for (int i = 0; i < 3; i++) c[6+i] = c[3+i];        // degenerate
      end else if (kind < 5) begin
        // point near the segment interior to favor region 3
        for (int i = 0; i < 3; i++) begin
          t = ($signed(c[3+i]) + $signed(c[6+i])) / 2 + $signed($urandom_range(0, 64)) - 32;
          c[i] = t[15:0];
        end
      end
      add_query(c);
      if (n == 700) begin
        wait (query_q.size() == 0);
        hold_sender = 1'b1;
        wait (dist_q.size() == 0 && !s_axis_tvalid_i);
        hold_sender = 1'b0;
      end
    end

    wait (query_q.size() == 0 && !s_axis_tvalid_i);
    wait (dist_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("sent %0d queries, checked %0d results", n_sent, n_recv);
    $display("regions: degen %0d before %0d past %0d interior %0d",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
    if (errors == 0 && dist_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/psd_pkg.sv
design/psd_div_cell.sv
design/psd_sqrt_cell.sv
design/point_segment_distance_3d_unit.sv
verif/tb.sv
